// ----- rtl/qfgt_pkg.sv -----
package qfgt_pkg;

  // Problem size and field widths.
  localparam int MAX_VARS = 64;
  localparam int VAR_W    = $clog2(MAX_VARS);
  localparam int SIZE_W   = VAR_W + 1;
  localparam int MAT_AW   = 2 * VAR_W;
  localparam int COEF_W   = 16;
  localparam int GAIN_W   = 32;
  localparam int TOTAL_W  = 48;
  localparam int MODE_W   = 3;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_W  = 32;
  localparam int OUT_W = 88;

  // Mode codes of an input transfer.
  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INCLUDE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EXCLUDE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TOGGLE  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_TOT_RD,
    ST_TOT,
    ST_OUT_RD,
    ST_OUT
  } state_t;

  typedef enum logic {
    SW_CLEAR,
    SW_FLIP
  } sweep_t;

  // Write port of the coefficient matrix.
  typedef struct packed {
    logic              we;
    logic [MAT_AW-1:0] addr;
    logic [COEF_W-1:0] data;
  } mat_wr_t;

  // Write port of the gain store.
  typedef struct packed {
    logic              we;
    logic [VAR_W-1:0]  addr;
    logic [GAIN_W-1:0] data;
  } gain_wr_t;

endpackage

// ----- rtl/qfgt_alu.sv -----
// Shared adder/subtractor used for every gain and objective update.
module qfgt_alu (
  input  logic [qfgt_pkg::TOTAL_W-1:0] a,
  input  logic [qfgt_pkg::TOTAL_W-1:0] b,
  input  logic                         sub,
  output logic [qfgt_pkg::TOTAL_W-1:0] res
);

  // Two's complement add or subtract; the result wraps.
  assign res = sub ? (a - b) : (a + b);

endmodule

// ----- rtl/qfgt_mat_mem.sv -----
// Coefficient matrix: one write port, two registered read ports.
module qfgt_mat_mem (
  input  logic                              clk,
  input  qfgt_pkg::mat_wr_t                 wr,
  input  logic [qfgt_pkg::MAT_AW-1:0]       raddr_a,
  input  logic [qfgt_pkg::MAT_AW-1:0]       raddr_b,
  output logic [qfgt_pkg::COEF_W-1:0]       rdata_a,
  output logic [qfgt_pkg::COEF_W-1:0]       rdata_b
);

  logic [qfgt_pkg::COEF_W-1:0] mem [qfgt_pkg::MAX_VARS*qfgt_pkg::MAX_VARS];
  logic [qfgt_pkg::COEF_W-1:0] rdata_a_r;
  logic [qfgt_pkg::COEF_W-1:0] rdata_b_r;

  // Write and read are both synchronous; contents start undefined.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ----- rtl/qfgt_gain_mem.sv -----
// Gain store with one valid bit per entry; an entry never written reads as zero.
module qfgt_gain_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qfgt_pkg::gain_wr_t          wr,
  input  logic [qfgt_pkg::VAR_W-1:0]  raddr,
  output logic [qfgt_pkg::GAIN_W-1:0] rdata
);

  logic [qfgt_pkg::GAIN_W-1:0]   mem [qfgt_pkg::MAX_VARS];
  logic [qfgt_pkg::MAX_VARS-1:0] valid_r;
  logic [qfgt_pkg::GAIN_W-1:0]   rdata_r;

  // Valid bits are cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // Array write and registered read.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= valid_r[raddr] ? mem[raddr] : '0;
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/qubo_flip_gain_tracker.sv -----
// Channel | Direction | Payload
// in_     | slave     | in_tdata:  mode[2:0] index[8:3] column[14:9] coefficient[30:15]
// out_    | master    | out_tdata: objective[47:0] selected[48] index_gain[80:49] changed[81]
// cfg_    | write     | cfg_data:  active_size[6:0]
//
// A load, a no-op flip or an unused mode passes from ST_IDLE through ST_OUT_RD
// and ST_OUT to the result register. A flip makes one pass over the active variables,
// paced by the two-port matrix read and the shared adder, then ST_TOT_RD and ST_TOT.
// A clear rewrites all MAX_VARS gains, one gain rewritten per cycle.
// Reset clears selection, gains (through valid bits) and the objective; the
// matrix is undefined until loaded. A held result does not block the next input
// transfer; only the finish of that next item waits on out_tready.
module qubo_flip_gain_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [qfgt_pkg::IN_W-1:0]     in_tdata,  // mode, index, column, coefficient
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [qfgt_pkg::OUT_W-1:0]    out_tdata, // objective, selected, index_gain, changed
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qfgt_pkg::SIZE_W-1:0]   cfg_data
);

  localparam int PAD_W = qfgt_pkg::OUT_W - qfgt_pkg::TOTAL_W - qfgt_pkg::GAIN_W - 2;

  qfgt_pkg::state_t state_r, state_nxt;
  qfgt_pkg::sweep_t sweep_r;

  logic [qfgt_pkg::SIZE_W-1:0]   active_size_r;
  logic [qfgt_pkg::SIZE_W-1:0]   n_cur;
  logic [qfgt_pkg::SIZE_W-1:0]   n_r;
  logic [qfgt_pkg::SIZE_W-1:0]   sweep_end;
  logic [qfgt_pkg::SIZE_W-1:0]   j_r;
  logic [qfgt_pkg::VAR_W-1:0]    p_j_r;
  logic                          p_vld_r;
  logic [qfgt_pkg::VAR_W-1:0]    idx_r;
  logic                          want_r;
  logic                          changed_r;
  logic [qfgt_pkg::MAX_VARS-1:0] sel_r;
  logic [qfgt_pkg::TOTAL_W-1:0]  total_r;
  logic                          out_valid_r;
  logic [qfgt_pkg::OUT_W-1:0]    out_data_r;

  logic [qfgt_pkg::MODE_W-1:0]   in_mode;
  logic [qfgt_pkg::VAR_W-1:0]    in_index;
  logic [qfgt_pkg::VAR_W-1:0]    in_column;
  logic [qfgt_pkg::COEF_W-1:0]   in_coef;
  logic                          accept;
  logic                          is_flip_mode;
  logic                          cur_sel;
  logic                          want;
  logic                          do_flip;
  logic                          issue;
  logic                          out_free;

  qfgt_pkg::mat_wr_t             mat_wr;
  logic [qfgt_pkg::MAT_AW-1:0]   mat_raddr_a;
  logic [qfgt_pkg::MAT_AW-1:0]   mat_raddr_b;
  logic [qfgt_pkg::COEF_W-1:0]   qa;
  logic [qfgt_pkg::COEF_W-1:0]   qb;
  qfgt_pkg::gain_wr_t            gain_wr;
  logic [qfgt_pkg::VAR_W-1:0]    gain_raddr;
  logic [qfgt_pkg::GAIN_W-1:0]   gain_q;
  logic [qfgt_pkg::GAIN_W-1:0]   pair_sum;
  logic [qfgt_pkg::TOTAL_W-1:0]  alu_a;
  logic [qfgt_pkg::TOTAL_W-1:0]  alu_b;
  logic                          alu_sub;
  logic [qfgt_pkg::TOTAL_W-1:0]  alu_res;

  // Field unpacking of the input transfer.
  assign in_mode   = in_tdata[2:0];
  assign in_index  = in_tdata[8:3];
  assign in_column = in_tdata[14:9];
  assign in_coef   = in_tdata[30:15];

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Active size saturated to the matrix dimension.
  assign n_cur = (active_size_r > qfgt_pkg::SIZE_W'(qfgt_pkg::MAX_VARS)) ?
                 qfgt_pkg::SIZE_W'(qfgt_pkg::MAX_VARS) : active_size_r;

  // Flip decision: the bounds check comes before the state check.
  always_comb begin
    is_flip_mode = in_mode inside {qfgt_pkg::MODE_INCLUDE, qfgt_pkg::MODE_EXCLUDE,
                                   qfgt_pkg::MODE_TOGGLE};
    cur_sel = sel_r[in_index];
    case (in_mode)
      qfgt_pkg::MODE_INCLUDE: want = 1'b1;
      qfgt_pkg::MODE_EXCLUDE: want = 1'b0;
      default:                want = !cur_sel;
    endcase
    do_flip = is_flip_mode && ({1'b0, in_index} < n_cur) && (want != cur_sel);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qfgt_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mode == qfgt_pkg::MODE_CLEAR || do_flip) begin
            state_nxt = qfgt_pkg::ST_SWEEP;
          end else begin
            state_nxt = qfgt_pkg::ST_OUT_RD;
          end
        end
      end
      qfgt_pkg::ST_SWEEP: begin
        if (!issue) begin
          state_nxt = (sweep_r == qfgt_pkg::SW_CLEAR) ? qfgt_pkg::ST_OUT_RD
                                                       : qfgt_pkg::ST_TOT_RD;
        end
      end
      qfgt_pkg::ST_TOT_RD: state_nxt = qfgt_pkg::ST_TOT;
      qfgt_pkg::ST_TOT:    state_nxt = qfgt_pkg::ST_OUT_RD;
      qfgt_pkg::ST_OUT_RD: state_nxt = qfgt_pkg::ST_OUT;
      qfgt_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = qfgt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qfgt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: memory ports and the operands of the shared adder.
  always_comb begin
    in_tready   = (state_r == qfgt_pkg::ST_IDLE);
    sweep_end   = (sweep_r == qfgt_pkg::SW_CLEAR) ? qfgt_pkg::SIZE_W'(qfgt_pkg::MAX_VARS) : n_r;
    issue       = (state_r == qfgt_pkg::ST_SWEEP) && (j_r < sweep_end);

    mat_wr.we   = accept && (in_mode == qfgt_pkg::MODE_LOAD);
    mat_wr.addr = {in_index, in_column};
    mat_wr.data = in_coef;

    mat_raddr_a = (sweep_r == qfgt_pkg::SW_CLEAR) ? {j_r[qfgt_pkg::VAR_W-1:0], j_r[qfgt_pkg::VAR_W-1:0]}
                                                   : {idx_r, j_r[qfgt_pkg::VAR_W-1:0]};
    mat_raddr_b = {j_r[qfgt_pkg::VAR_W-1:0], idx_r};

    gain_raddr  = (state_r == qfgt_pkg::ST_SWEEP) ? j_r[qfgt_pkg::VAR_W-1:0] : idx_r;

    pair_sum = {{(qfgt_pkg::GAIN_W-qfgt_pkg::COEF_W){qa[qfgt_pkg::COEF_W-1]}}, qa}
             + {{(qfgt_pkg::GAIN_W-qfgt_pkg::COEF_W){qb[qfgt_pkg::COEF_W-1]}}, qb};

    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      qfgt_pkg::ST_SWEEP: begin
        if (sweep_r == qfgt_pkg::SW_CLEAR) begin
          // Gain restarts at the diagonal entry for an active variable.
          if ({1'b0, p_j_r} < n_r) begin
            alu_b = {{(qfgt_pkg::TOTAL_W-qfgt_pkg::COEF_W){qa[qfgt_pkg::COEF_W-1]}}, qa};
          end
        end else begin
          alu_a   = {{(qfgt_pkg::TOTAL_W-qfgt_pkg::GAIN_W){gain_q[qfgt_pkg::GAIN_W-1]}}, gain_q};
          alu_b   = {{(qfgt_pkg::TOTAL_W-qfgt_pkg::GAIN_W){pair_sum[qfgt_pkg::GAIN_W-1]}},
                     pair_sum};
          alu_sub = !want_r;
        end
      end
      qfgt_pkg::ST_TOT: begin
        alu_a   = total_r;
        alu_b   = {{(qfgt_pkg::TOTAL_W-qfgt_pkg::GAIN_W){gain_q[qfgt_pkg::GAIN_W-1]}}, gain_q};
        alu_sub = !want_r;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase

    // The flipped variable keeps its own gain.
    gain_wr.we   = p_vld_r && ((sweep_r == qfgt_pkg::SW_CLEAR) || (p_j_r != idx_r));
    gain_wr.addr = p_j_r;
    gain_wr.data = alu_res[qfgt_pkg::GAIN_W-1:0];
  end

  qfgt_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  qfgt_mat_mem u_mat_mem (
    .clk     (clk),
    .wr      (mat_wr),
    .raddr_a (mat_raddr_a),
    .raddr_b (mat_raddr_b),
    .rdata_a (qa),
    .rdata_b (qb)
  );

  qfgt_gain_mem u_gain_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (gain_wr),
    .raddr (gain_raddr),
    .rdata (gain_q)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= qfgt_pkg::ST_IDLE;
      active_size_r <= qfgt_pkg::SIZE_W'(qfgt_pkg::MAX_VARS);
      sel_r         <= '0;
      total_r       <= '0;
      p_vld_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_vld_r <= issue;

      if (cfg_valid && cfg_ready) begin
        active_size_r <= cfg_data;
      end

      if (accept && in_mode == qfgt_pkg::MODE_CLEAR) begin
        sel_r   <= '0;
        total_r <= '0;
      end

      if (state_r == qfgt_pkg::ST_TOT) begin
        total_r       <= alu_res;
        sel_r[idx_r]  <= want_r;
      end

      // The result register frees the output side from the sequencer.
      if (state_r == qfgt_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item context, sweep counters and the result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r     <= in_index;
      want_r    <= want;
      changed_r <= do_flip;
      n_r       <= n_cur;
      j_r       <= '0;
      sweep_r   <= (in_mode == qfgt_pkg::MODE_CLEAR) ? qfgt_pkg::SW_CLEAR : qfgt_pkg::SW_FLIP;
    end else if (issue) begin
      j_r <= j_r + 1'b1;
    end
    p_j_r <= j_r[qfgt_pkg::VAR_W-1:0];

    if (state_r == qfgt_pkg::ST_OUT && out_free) begin
      out_data_r <= {{PAD_W{1'b0}}, changed_r, gain_q, sel_r[idx_r], total_r};
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // An accepted item keeps the input side closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again right after a transfer");

  // The sweep counter never runs past its end.
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qfgt_pkg::ST_SWEEP) |-> (j_r <= sweep_end))
    else $error("sweep counter beyond its end");

  // Gain writes of the sweep land only while the sweep is running.
  a_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (state_r == qfgt_pkg::ST_SWEEP))
    else $error("gain write outside the sweep");

  // The flipped variable's gain is never rewritten by its own flip.
  a_no_self_write: assert property (@(posedge clk) disable iff (!rst_n)
    (gain_wr.we && sweep_r == qfgt_pkg::SW_FLIP) |-> (gain_wr.addr != idx_r))
    else $error("flip rewrote the gain of the flipped variable");

  // The objective update is always followed by the result read.
  a_tot_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qfgt_pkg::ST_TOT) |=> (state_r == qfgt_pkg::ST_OUT_RD))
    else $error("objective update not followed by result read");

endmodule
